// ===== design/gbs_pkg.sv =====
// Shared types, constants and helpers for the greedy box suppression block.
`default_nettype none

package gbs_pkg;

  localparam int unsigned MAX_KEPT   = 64;
  localparam int unsigned COORD_BITS = 12;
  localparam int unsigned FIELD_BITS = 12;
  localparam int unsigned RATIO_BITS = 8;

  localparam int unsigned KEEP_AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int unsigned KEEP_CW = $clog2(MAX_KEPT + 1);

  localparam int unsigned AREA_BITS = 2 * COORD_BITS;
  localparam int unsigned UNI_BITS  = AREA_BITS + 1;
  localparam int unsigned PROD_BITS = UNI_BITS + RATIO_BITS;

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [FIELD_BITS-1:0] FIELD_MAX = '1;
  localparam logic [RATIO_BITS-1:0] NUM_RESET = RATIO_BITS'(3);
  localparam logic [RATIO_BITS-1:0] DEN_RESET = RATIO_BITS'(10);

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t l;
    coord_t t;
    coord_t r;
    coord_t b;
  } box_t;

  typedef struct packed {
    logic                  first;
    logic [FIELD_BITS-1:0] idx;
    box_t                  box;
  } job_t;

  typedef enum logic {
    CFG_NUM = 1'b0,
    CFG_DEN = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } back_state_e;

  function automatic coord_t span(input coord_t lo, input coord_t hi);
    span = (hi > lo) ? coord_t'(hi - lo) : '0;
  endfunction

  function automatic coord_t cmax(input coord_t a, input coord_t b);
    cmax = (a > b) ? a : b;
  endfunction

  function automatic coord_t cmin(input coord_t a, input coord_t b);
    cmin = (a < b) ? a : b;
  endfunction

endpackage

`default_nettype wire

// ===== design/gbs_ifs.sv =====
// Request channel interfaces: incoming boxes and kept-box results.
`default_nettype none

interface gbs_box_if;
  import gbs_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  first_of_set;
  logic [FIELD_BITS-1:0] left;
  logic [FIELD_BITS-1:0] top;
  logic [FIELD_BITS-1:0] right;
  logic [FIELD_BITS-1:0] bottom;

  modport source (output valid, first_of_set, left, top, right, bottom, input ready);
  modport sink   (input valid, first_of_set, left, top, right, bottom, output ready);
endinterface

interface gbs_kept_if;
  import gbs_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [FIELD_BITS-1:0] box_index;
  logic [FIELD_BITS-1:0] kept_rank;
  logic [FIELD_BITS-1:0] kept_left;
  logic [FIELD_BITS-1:0] kept_top;
  logic [FIELD_BITS-1:0] kept_right;
  logic [FIELD_BITS-1:0] kept_bottom;
  logic                  store_full;

  modport source (output valid, box_index, kept_rank, kept_left, kept_top, kept_right,
                  kept_bottom, store_full, input ready);
  modport sink   (input valid, box_index, kept_rank, kept_left, kept_top, kept_right,
                  kept_bottom, store_full, output ready);
endinterface

`default_nettype wire

// ===== design/gbs_front.sv =====
// Front end: accepts box requests, numbers them within the set, pushes jobs.
`default_nettype none

module gbs_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  gbs_box_if.sink            box_i,
  output gbs_pkg::job_t      push_data_o,
  output logic               push_valid_o,
  input  wire logic          push_ready_i
);
  import gbs_pkg::*;

  logic [FIELD_BITS-1:0] arrival_q, arrival_d;
  logic [FIELD_BITS-1:0] idx;
  logic                  accept;

  assign box_i.ready  = push_ready_i;
  assign push_valid_o = box_i.valid;
  assign accept       = box_i.valid && push_ready_i;

  assign idx       = box_i.first_of_set ? '0 : arrival_q;
  assign arrival_d = idx + FIELD_BITS'(1);

  assign push_data_o.first = box_i.first_of_set;
  assign push_data_o.idx   = idx;
  assign push_data_o.box.l = COORD_BITS'(box_i.left);
  assign push_data_o.box.t = COORD_BITS'(box_i.top);
  assign push_data_o.box.r = COORD_BITS'(box_i.right);
  assign push_data_o.box.b = COORD_BITS'(box_i.bottom);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arrival_q <= '0;
    end else if (accept) begin
      arrival_q <= arrival_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/gbs_fifo.sv =====
// Short job queue between front and back ends.
`default_nettype none

module gbs_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire gbs_pkg::job_t push_data_i,
  input  wire logic          push_valid_i,
  output logic               push_ready_o,
  output gbs_pkg::job_t      pop_data_o,
  output logic               pop_valid_o,
  input  wire logic          pop_ready_i
);
  import gbs_pkg::*;

  job_t                entry_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FIFO_CW-1:0]  cnt_q;
  logic                push, pop;

  assign push_ready_o = (cnt_q != FIFO_CW'(FIFO_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + FIFO_AW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + FIFO_CW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - FIFO_CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/gbs_back.sv =====
// Back end: scans the kept-box memory for overlap, emits survivors and stores them while the store has room.
`default_nettype none

module gbs_back (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire gbs_pkg::job_t                  pop_data_i,
  input  wire logic                           pop_valid_i,
  output logic                                pop_ready_o,
  input  wire logic [gbs_pkg::RATIO_BITS-1:0] num_i,
  input  wire logic [gbs_pkg::RATIO_BITS-1:0] den_i,
  gbs_kept_if.source                          kept_o
);
  import gbs_pkg::*;

  localparam int unsigned PIPE_DEPTH = 5;

  back_state_e state_q, state_d;

  job_t                  job_q, job_d;
  logic [AREA_BITS-1:0]  area_new_q, area_new_d;
  logic [FIELD_BITS-1:0] kept_total_q, kept_total_d, kt_eff;
  logic [KEEP_CW-1:0]    stored_q, stored_d;
  logic [KEEP_CW-1:0]    rd_cnt_q, rd_cnt_d;
  logic                  supp_q, supp_d;
  logic [PIPE_DEPTH-1:0] pv_q;

  box_t                  mem_q [MAX_KEPT];
  box_t                  mem_rd_q;
  logic                  rd_en, wr_en;

  coord_t                iw_q, ih_q, kw_q, kh_q;
  logic [AREA_BITS-1:0]  inter_q, karea_q, inter_c_q;
  logic [UNI_BITS-1:0]   uni_q;
  logic [PROD_BITS-1:0]  lhs_q, rhs_q;

  logic                  out_free, out_load;
  logic                  kept_valid_q;
  logic [FIELD_BITS-1:0] out_idx_q, out_rank_q;
  box_t                  out_box_q;
  logic                  out_full_q;

  assign out_free = !kept_valid_q || kept_o.ready;

  always_comb begin
    state_d      = state_q;
    job_d        = job_q;
    area_new_d   = area_new_q;
    kept_total_d = kept_total_q;
    stored_d     = stored_q;
    rd_cnt_d     = rd_cnt_q;
    supp_d       = supp_q;
    pop_ready_o  = 1'b0;
    rd_en        = 1'b0;
    wr_en        = 1'b0;
    out_load     = 1'b0;
    kt_eff       = pop_data_i.first ? '0 : kept_total_q;

    unique case (state_q)
      ST_IDLE: begin
        pop_ready_o = 1'b1;
        if (pop_valid_i) begin
          job_d        = pop_data_i;
          kept_total_d = kt_eff;
          stored_d     = (kt_eff < FIELD_BITS'(MAX_KEPT)) ? KEEP_CW'(kt_eff)
                                                          : KEEP_CW'(MAX_KEPT);
          area_new_d   = AREA_BITS'(span(pop_data_i.box.l, pop_data_i.box.r)) *
                         AREA_BITS'(span(pop_data_i.box.t, pop_data_i.box.b));
          rd_cnt_d     = '0;
          supp_d       = 1'b0;
          state_d      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (pv_q[PIPE_DEPTH-1] && (lhs_q > rhs_q)) begin
          supp_d = 1'b1;
        end
        if (rd_cnt_q != stored_q) begin
          rd_en    = 1'b1;
          rd_cnt_d = rd_cnt_q + KEEP_CW'(1);
        end else if (pv_q == '0) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (supp_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_load = 1'b1;
          wr_en    = (kept_total_q < FIELD_BITS'(MAX_KEPT));
          if (kept_total_q != FIELD_MAX) begin
            kept_total_d = kept_total_q + FIELD_BITS'(1);
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      kept_total_q <= '0;
      stored_q     <= '0;
      rd_cnt_q     <= '0;
      supp_q       <= 1'b0;
      pv_q         <= '0;
      kept_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      kept_total_q <= kept_total_d;
      stored_q     <= stored_d;
      rd_cnt_q     <= rd_cnt_d;
      supp_q       <= supp_d;
      pv_q         <= {pv_q[PIPE_DEPTH-2:0], rd_en};
      if (out_load) begin
        kept_valid_q <= 1'b1;
      end else if (kept_o.ready) begin
        kept_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    job_q      <= job_d;
    area_new_q <= area_new_d;
  end

  // kept-box store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[kept_total_q[KEEP_AW-1:0]] <= job_q.box;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      mem_rd_q <= mem_q[rd_cnt_q[KEEP_AW-1:0]];
    end
  end

  // overlap pipeline
  always_ff @(posedge clk_i) begin
    iw_q      <= span(cmax(job_q.box.l, mem_rd_q.l), cmin(job_q.box.r, mem_rd_q.r));
    ih_q      <= span(cmax(job_q.box.t, mem_rd_q.t), cmin(job_q.box.b, mem_rd_q.b));
    kw_q      <= span(mem_rd_q.l, mem_rd_q.r);
    kh_q      <= span(mem_rd_q.t, mem_rd_q.b);
    inter_q   <= AREA_BITS'(iw_q) * AREA_BITS'(ih_q);
    karea_q   <= AREA_BITS'(kw_q) * AREA_BITS'(kh_q);
    uni_q     <= UNI_BITS'(area_new_q) + UNI_BITS'(karea_q) - UNI_BITS'(inter_q);
    inter_c_q <= inter_q;
    lhs_q     <= PROD_BITS'(inter_c_q) * PROD_BITS'(den_i);
    rhs_q     <= PROD_BITS'(num_i) * PROD_BITS'(uni_q);
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_idx_q  <= job_q.idx;
      out_rank_q <= kept_total_q;
      out_box_q  <= job_q.box;
      out_full_q <= !(kept_total_q < FIELD_BITS'(MAX_KEPT));
    end
  end

  assign kept_o.valid       = kept_valid_q;
  assign kept_o.box_index   = out_idx_q;
  assign kept_o.kept_rank   = out_rank_q;
  assign kept_o.kept_left   = FIELD_BITS'(out_box_q.l);
  assign kept_o.kept_top    = FIELD_BITS'(out_box_q.t);
  assign kept_o.kept_right  = FIELD_BITS'(out_box_q.r);
  assign kept_o.kept_bottom = FIELD_BITS'(out_box_q.b);
  assign kept_o.store_full  = out_full_q;

  a_wr_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (kept_total_q < FIELD_BITS'(MAX_KEPT)))
    else $error("store write past capacity");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (rd_cnt_q <= stored_q))
    else $error("scan index beyond stored count");

  a_done_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |-> (pv_q == '0))
    else $error("decision taken with compares in flight");

  a_emit_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(kept_valid_q) |-> ($past(state_q) == ST_DONE) && !$past(supp_q))
    else $error("result emitted outside decision");

endmodule

`default_nettype wire

// ===== design/greedy_box_suppression.sv =====
// Top level: greedy IoU box suppression with decoupled front and back ends.
// The back end takes a new box only after it has finished the last one; it scans the
// kept-box memory through its single read port, one box per cycle.
// Reset: set counters cleared, ratio set to 3/10; kept-box memory is not cleared.
`default_nettype none

module greedy_box_suppression (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic                           cfg_idx_i,
  input  wire logic [gbs_pkg::RATIO_BITS-1:0] cfg_data_i,
  gbs_box_if.sink                             box_i,
  gbs_kept_if.source                          kept_o
);
  import gbs_pkg::*;

  logic [RATIO_BITS-1:0] num_q, den_q;
  job_t                  push_data, pop_data;
  logic                  push_valid, push_ready, pop_valid, pop_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q <= NUM_RESET;
      den_q <= DEN_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_NUM: num_q <= cfg_data_i;
        CFG_DEN: den_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  gbs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .box_i        (box_i),
    .push_data_o  (push_data),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready)
  );

  gbs_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (push_data),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .pop_data_o   (pop_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready)
  );

  gbs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_data_i  (pop_data),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .num_i       (num_q),
    .den_i       (den_q),
    .kept_o      (kept_o)
  );

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Testbench for greedy_box_suppression: drives boxes, predicts kept results, checks each one.
`timescale 1ns / 1ps

module tb;
  import gbs_pkg::*;

  localparam int unsigned SETTLE_CYCLES  = 250;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned MAX_GAP        = 17;
  localparam int          COORD_TOP      = (1 << COORD_BITS) - 1;
  localparam int unsigned LONG_SET       = MAX_KEPT + 36;

  typedef struct packed {
    logic [FIELD_BITS-1:0] idx;
    logic [FIELD_BITS-1:0] rank;
    box_t                  box;
    logic                  full;
  } kept_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  cfg_reg_e              cfg_idx;
  logic [RATIO_BITS-1:0] cfg_data;

  gbs_box_if  box_ch ();
  gbs_kept_if kept_ch ();

  greedy_box_suppression i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .box_i      (box_ch),
    .kept_o     (kept_ch)
  );

  box_t                  kept_mem [MAX_KEPT];
  logic [FIELD_BITS-1:0] set_kept;
  logic [FIELD_BITS-1:0] set_seen;
  logic [RATIO_BITS-1:0] ratio_num;
  logic [RATIO_BITS-1:0] ratio_den;
  kept_t                 kept_q [$];

  bit          idle_en = 1'b1;
  int unsigned errors  = 0;
  int unsigned quiet   = 0;
  int unsigned stall   = 0;

  always #5 clk = ~clk;

  function automatic longint unsigned extent(input coord_t lo, input coord_t hi);
    return (hi > lo) ? 64'(hi - lo) : 64'd0;
  endfunction

  function automatic longint unsigned area(input box_t b);
    return extent(b.l, b.r) * extent(b.t, b.b);
  endfunction

  function automatic bit too_close(input box_t a, input box_t k);
    longint unsigned ov;
    longint unsigned un;
    ov = extent((a.l > k.l) ? a.l : k.l, (a.r < k.r) ? a.r : k.r)
       * extent((a.t > k.t) ? a.t : k.t, (a.b < k.b) ? a.b : k.b);
    un = area(a) + area(k) - ov;
    return (ov * ratio_den) > (un * ratio_num);
  endfunction

  function automatic void predict_kept(input logic first, input box_t nb);
    logic [FIELD_BITS-1:0] idx;
    int unsigned           n_stored;
    int unsigned           i;
    if (first) begin
      set_kept = '0;
      set_seen = '0;
    end
    idx      = set_seen;
    set_seen = set_seen + 1'b1;
    n_stored = (set_kept < MAX_KEPT) ? set_kept : MAX_KEPT;
    for (i = 0; i < n_stored; i++) begin
      if (too_close(nb, kept_mem[i])) return;
    end
    if (set_kept < MAX_KEPT) kept_mem[set_kept[KEEP_AW-1:0]] = nb;
    kept_q.push_back('{idx: idx, rank: set_kept, box: nb, full: (set_kept >= MAX_KEPT)});
    if (set_kept != FIELD_MAX) set_kept = set_kept + 1'b1;
  endfunction

  function automatic int unsigned draw_gap();
    if (!idle_en || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  function automatic coord_t pin(input int v);
    return (v < 0) ? coord_t'(0) : (v > COORD_TOP) ? coord_t'(COORD_TOP) : coord_t'(v);
  endfunction

  function automatic int jitter();
    return int'($urandom_range(0, 48)) - 24;
  endfunction

  function automatic box_t any_box();
    return box_t'{coord_t'($urandom_range(0, COORD_TOP)), coord_t'($urandom_range(0, COORD_TOP)),
                  coord_t'($urandom_range(0, COORD_TOP)), coord_t'($urandom_range(0, COORD_TOP))};
  endfunction

  function automatic box_t anchor_box();
    box_t a;
    a.l = coord_t'($urandom_range(0, COORD_TOP - 300));
    a.t = coord_t'($urandom_range(0, COORD_TOP - 300));
    a.r = a.l + coord_t'($urandom_range(20, 295));
    a.b = a.t + coord_t'($urandom_range(20, 295));
    return a;
  endfunction

  function automatic box_t near_box(input box_t a);
    return box_t'{pin(int'(a.l) + jitter()), pin(int'(a.t) + jitter()),
                  pin(int'(a.r) + jitter()), pin(int'(a.b) + jitter())};
  endfunction

  task automatic report_error(input string msg);
    if (errors < 100) $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  task automatic compare_field(input string name, input logic [FIELD_BITS-1:0] want,
                               input logic [FIELD_BITS-1:0] got);
    if (want !== got) report_error($sformatf("%s expected %0d got %0d", name, want, got));
  endtask

  // one request per box; valid stays high when the next box follows at once
  task automatic send_box(input logic first, input box_t b);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      box_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    box_ch.valid        <= 1'b1;
    box_ch.first_of_set <= first;
    box_ch.left         <= b.l;
    box_ch.top          <= b.t;
    box_ch.right        <= b.r;
    box_ch.bottom       <= b.b;
    @(posedge clk);
    while (box_ch.ready !== 1'b1) @(posedge clk);
    predict_kept(first, b);
  endtask

  task automatic settle();
    box_ch.valid <= 1'b0;
    while (kept_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_ratio(input logic [RATIO_BITS-1:0] num, input logic [RATIO_BITS-1:0] den);
    settle();
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_NUM;
    cfg_data <= num;
    @(posedge clk);
    cfg_idx  <= CFG_DEN;
    cfg_data <= den;
    @(posedge clk);
    cfg_we   <= 1'b0;
    @(posedge clk);
    ratio_num = num;
    ratio_den = den;
  endtask

  task automatic run_sets(input int unsigned n_items);
    box_t        anchors [4];
    int unsigned sent;
    int unsigned set_len;
    int unsigned j;
    int unsigned k;
    sent = 0;
    while (sent < n_items) begin
      set_len = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 90) : $urandom_range(1, 30);
      for (k = 0; k < 4; k++) anchors[k] = anchor_box();
      for (j = 0; j < set_len && sent < n_items; j++) begin
        if ($urandom_range(0, 4) == 0) begin
          send_box($urandom_range(0, 9) == 0, any_box());
        end else begin
          send_box(j == 0, near_box(anchors[$urandom_range(0, 3)]));
        end
        sent++;
      end
    end
  endtask

  task automatic test_directed();
    idle_en = 1'b1;
    send_box(1'b1, box_t'{12'd0, 12'd0, 12'd4095, 12'd4095});
    send_box(1'b0, box_t'{12'd0, 12'd0, 12'd4095, 12'd4095});
    send_box(1'b0, box_t'{12'd4095, 12'd4095, 12'd0, 12'd0});
    send_box(1'b0, box_t'{12'd100, 12'd100, 12'd100, 12'd200});
    send_box(1'b0, box_t'{12'd0, 12'd0, 12'd0, 12'd0});
    send_box(1'b1, box_t'{12'd1000, 12'd1000, 12'd1013, 12'd1100});
    // overlap ratio exactly at 3/10, then just above
    send_box(1'b0, box_t'{12'd1007, 12'd1000, 12'd1020, 12'd1100});
    send_box(1'b0, box_t'{12'd1006, 12'd1000, 12'd1019, 12'd1100});
    send_box(1'b0, box_t'{12'd0, 12'd0, 12'd4095, 12'd4095});
    send_box(1'b0, box_t'{12'd4095, 12'd0, 12'd4095, 12'd4095});
    send_box(1'b1, box_t'{12'd4094, 12'd4094, 12'd4095, 12'd4095});
    send_box(1'b0, box_t'{12'd4094, 12'd4094, 12'd4095, 12'd4095});
    send_box(1'b1, box_t'{12'd10, 12'd10, 12'd20, 12'd20});
    send_box(1'b1, box_t'{12'd10, 12'd10, 12'd20, 12'd20});
  endtask

  task automatic ratio_phase(input logic [RATIO_BITS-1:0] num, input logic [RATIO_BITS-1:0] den);
    set_ratio(num, den);
    send_box(1'b1, box_t'{12'd200, 12'd200, 12'd300, 12'd300});
    send_box(1'b0, box_t'{12'd200, 12'd200, 12'd300, 12'd300});
    send_box(1'b0, box_t'{12'd300, 12'd200, 12'd400, 12'd300});
    send_box(1'b0, box_t'{12'd299, 12'd200, 12'd399, 12'd300});
    run_sets(25);
  endtask

  task automatic test_ratio_extremes();
    idle_en = 1'b1;
    ratio_phase(8'd0, 8'd1);
    ratio_phase(8'd255, 8'd1);
    ratio_phase(8'd0, 8'd255);
    ratio_phase(8'd255, 8'd255);
    ratio_phase(8'd1, 8'd255);
    ratio_phase(8'd3, 8'd0);
  endtask

  task automatic test_store_full();
    int unsigned k;
    coord_t      x;
    coord_t      y;
    set_ratio(8'd0, 8'd1);
    idle_en = 1'b1;
    for (k = 0; k <= MAX_KEPT; k++) begin
      x = coord_t'((k % 64) * 64);
      y = coord_t'((k / 64) * 64);
      send_box(k == 0, box_t'{x, y, x + 12'd50, y + 12'd50});
    end
    // the overflow box was never stored, so its copy survives
    send_box(1'b0, box_t'{x, y, x + 12'd50, y + 12'd50});
    send_box(1'b0, box_t'{12'd0, 12'd0, 12'd50, 12'd50});
    send_box(1'b0, box_t'{12'd4070, 12'd40, 12'd4095, 12'd90});
  endtask

  // zero-area boxes are always kept, so the set runs well past the store capacity
  task automatic test_counter_limits();
    int unsigned k;
    box_t        b;
    idle_en = 1'b0;
    for (k = 0; k < LONG_SET; k++) begin
      b = any_box();
      if (k % 2 == 0) b.r = coord_t'($urandom_range(0, b.l));
      else b.b = coord_t'($urandom_range(0, b.t));
      send_box(k == 0, b);
    end
  endtask

  task automatic test_random();
    int unsigned           phase;
    logic [RATIO_BITS-1:0] den;
    for (phase = 0; phase < 5; phase++) begin
      den = RATIO_BITS'($urandom_range(1, 255));
      set_ratio(RATIO_BITS'($urandom_range(0, den)), den);
      idle_en = (phase != 1);
      run_sets(30);
    end
  endtask

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      kept_ch.ready <= 1'b0;
      stall = 0;
    end else begin
      if (kept_ch.valid === 1'b1 && kept_ch.ready) stall = draw_gap();
      else if (stall != 0) stall = stall - 1;
      kept_ch.ready <= (stall == 0);
    end
  end

  always @(posedge clk) begin : check_kept
    kept_t want;
    if (rst_n && kept_ch.valid === 1'b1 && kept_ch.ready) begin
      if (kept_q.size() == 0) begin
        report_error($sformatf("result with nothing pending, box_index %0d", kept_ch.box_index));
      end else begin
        want = kept_q.pop_front();
        compare_field("box_index", want.idx, kept_ch.box_index);
        compare_field("kept_rank", want.rank, kept_ch.kept_rank);
        compare_field("kept_left", want.box.l, kept_ch.kept_left);
        compare_field("kept_top", want.box.t, kept_ch.kept_top);
        compare_field("kept_right", want.box.r, kept_ch.kept_right);
        compare_field("kept_bottom", want.box.b, kept_ch.kept_bottom);
        compare_field("store_full", FIELD_BITS'(want.full), FIELD_BITS'(kept_ch.store_full));
      end
    end
  end

  always @(posedge clk) begin
    if ((box_ch.valid && box_ch.ready) || (kept_ch.valid && kept_ch.ready)) quiet = 0;
    else quiet++;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_idx             <= CFG_NUM;
    cfg_data            <= '0;
    box_ch.valid        <= 1'b0;
    box_ch.first_of_set <= 1'b0;
    box_ch.left         <= '0;
    box_ch.top          <= '0;
    box_ch.right        <= '0;
    box_ch.bottom       <= '0;
    set_kept  = '0;
    set_seen  = '0;
    ratio_num = NUM_RESET;
    ratio_den = DEN_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_ratio_extremes();
    test_store_full();
    test_counter_limits();
    test_random();
    settle();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
